// ----- src/mted_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mted_pkg
// Shared types and constants of the multi-tap echo delay block.
// ----------------------------------------------------------------------------
package mted_pkg;

   // Default sizes of the block
   localparam int HISTORY_DEPTH_DEF = 65536;
   localparam int MAX_TAPS_DEF      = 16;
   localparam int SAMPLE_BITS_DEF   = 16;

   // Gains are in thousandths
   localparam int GAIN_SCALE = 1000;
   localparam int DECAY_BITS = 10;

   // Control register port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 17;

   // Register reset values
   localparam logic [16:0] DELAY_LENGTH_RST = 17'd46080;
   localparam logic [4:0]  TAP_COUNT_RST    = 5'd0;
   localparam logic [9:0]  DECAY_RST        = 10'd0;
   localparam logic [15:0] TAP_DISTANCE_RST = 16'd11300;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DELAY_LENGTH       = 3'd0,
      CSR_TAP_COUNT          = 3'd1,
      CSR_DECAY_PERMILLE     = 3'd2,
      CSR_FIRST_TAP_DISTANCE = 3'd3,
      CSR_TAP_SPACING        = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [16:0]           delay_length;
      logic [4:0]            tap_count;
      logic [DECAY_BITS-1:0] decay_permille;
      logic [15:0]           first_tap_distance;
      logic [15:0]           tap_spacing;
   } csr_regs_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DRY,
      ST_LOAD,
      ST_POS,
      ST_LAG,
      ST_MAC,
      ST_GAIN,
      ST_GQ,
      ST_GC,
      ST_GF,
      ST_FIN,
      ST_FQ,
      ST_FC
   } state_type;

endpackage

// ----- src/multi_tap_echo_delay.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_tap_echo_delay
// Multi-tap echo: dry sample plus decaying taps from a circular history.
// ----------------------------------------------------------------------------
// The time from one sample's acceptance to the next grows with the tap
// count and is set by the single shared multiplier, which serves in turn
// the dry scaling, each tap product, each gain update and the reciprocal
// divisions by 1000, and by the registered reads of the history and tap
// position memories.
// req_ready is high only while the block is idle; a finished result waits in
// an output register, so the next sample is accepted while it is pending.
// After reset a clearing sweep zeroes the history and the tap positions;
// no sample is accepted during it, while control register writes are
// taken at any time.
// ----------------------------------------------------------------------------
module multi_tap_echo_delay #(
   parameter int HISTORY_DEPTH = mted_pkg::HISTORY_DEPTH_DEF,
   parameter int MAX_TAPS      = mted_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS   = mted_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_echoed_sample,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mted_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mted_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   mted_pkg::csr_regs_type regs;

   // Control registers
   mted_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .regs      (regs)
   );

   // Sequencer and memories
   mted_core #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .MAX_TAPS      (MAX_TAPS),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .regs              (regs),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_echoed_sample (rsp_echoed_sample)
   );

endmodule

// ----- src/mted_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mted_csr
// Control registers of the echo delay, written through the csr channel.
// ----------------------------------------------------------------------------
module mted_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mted_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mted_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output mted_pkg::csr_regs_type              regs
);

   mted_pkg::csr_regs_type regs_ff;
   mted_pkg::csr_regs_type regs_in;

   // Writes are always taken
   assign csr_ready = 1'b1;
   assign regs      = regs_ff;

   // Register decode; unknown indexes are dropped
   always_comb begin
      regs_in = regs_ff;
      if (csr_valid) begin
         unique case (mted_pkg::csr_index_type'(csr_index))
            mted_pkg::CSR_DELAY_LENGTH:       regs_in.delay_length   = csr_wdata;
            mted_pkg::CSR_TAP_COUNT:          regs_in.tap_count      = csr_wdata[4:0];
            mted_pkg::CSR_DECAY_PERMILLE: begin
               regs_in.decay_permille = csr_wdata[mted_pkg::DECAY_BITS-1:0];
            end
            mted_pkg::CSR_FIRST_TAP_DISTANCE: regs_in.first_tap_distance = csr_wdata[15:0];
            mted_pkg::CSR_TAP_SPACING:        regs_in.tap_spacing    = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.delay_length       <= mted_pkg::DELAY_LENGTH_RST;
         regs_ff.tap_count          <= mted_pkg::TAP_COUNT_RST;
         regs_ff.decay_permille     <= mted_pkg::DECAY_RST;
         regs_ff.first_tap_distance <= mted_pkg::TAP_DISTANCE_RST;
         regs_ff.tap_spacing        <= mted_pkg::TAP_DISTANCE_RST;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

// ----- src/mted_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mted_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module mted_mul #(
   parameter int A_BITS = 26,
   parameter int B_BITS = 17
) (
   input  logic                             clock,
   input  logic signed [A_BITS-1:0]         op_a,
   input  logic signed [B_BITS-1:0]         op_b,
   output logic signed [A_BITS+B_BITS-1:0]  prod
);

   logic signed [A_BITS+B_BITS-1:0] prod_ff;
   logic signed [A_BITS+B_BITS-1:0] prod_in;

   // One product per cycle
   assign prod_in = op_a * op_b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- src/mted_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mted_core
// Sequencer, history and tap position memories of the echo delay. One
// multiplier is shared by the dry scaling, the tap products, the gain update
// and the two divisions by the gain scale.
// ----------------------------------------------------------------------------
module mted_core #(
   parameter int HISTORY_DEPTH = mted_pkg::HISTORY_DEPTH_DEF,
   parameter int MAX_TAPS      = mted_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS   = mted_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mted_pkg::csr_regs_type        regs,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_echoed_sample
);

   // Position and count widths
   localparam int AW  = $clog2(HISTORY_DEPTH);
   localparam int LW  = AW + 1;
   localparam int LCW = (LW > 17) ? LW : 17;
   localparam int TW  = $clog2(MAX_TAPS + 1);
   localparam int TIW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int TCW = (TW > 5) ? TW : 5;
   localparam int TGW = 16 + TW;
   localparam int MW  = (TGW > LW) ? TGW : LW;
   localparam int LGW = AW + 2;

   // Arithmetic widths; the gain bound allows for decay above the scale
   localparam int GB   = 11 + ((MAX_TAPS + 1) * 33 + 999) / 1000;
   localparam int XB   = GB + mted_pkg::DECAY_BITS;
   localparam int K1   = XB;
   localparam int MAGB = SAMPLE_BITS + 9;
   localparam int K2   = MAGB;
   localparam int ACCB = SAMPLE_BITS + GB + TW + 1;
   localparam int QW   = (GB > SAMPLE_BITS) ? GB : SAMPLE_BITS;
   localparam int A_BITS = ((XB > MAGB) ? XB : MAGB) + 1;
   localparam int B_BITS = (((GB + 1) > SAMPLE_BITS) ? (GB + 1) : SAMPLE_BITS) + 1;
   localparam int PB   = A_BITS + B_BITS;

   // Reciprocals of the gain scale
   localparam longint M1 = (64'sd1 <<< K1) / mted_pkg::GAIN_SCALE;
   localparam longint M2 = (64'sd1 <<< K2) / mted_pkg::GAIN_SCALE;

   // Accumulator clip bounds that keep the quotient in the sample range
   localparam longint SMAX   = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam longint ACC_HI = SMAX * mted_pkg::GAIN_SCALE + mted_pkg::GAIN_SCALE - 1;
   localparam longint ACC_LO = -(SMAX + 64'sd1) * mted_pkg::GAIN_SCALE
                               - mted_pkg::GAIN_SCALE + 1;

   // Clearing sweep
   localparam int CLR_DEPTH = (HISTORY_DEPTH > MAX_TAPS) ? HISTORY_DEPTH : MAX_TAPS;
   localparam int CW  = $clog2(CLR_DEPTH);
   localparam int CCW = CW + 1;

   // Memories
   logic [SAMPLE_BITS-1:0] hist_mem [HISTORY_DEPTH];
   logic [AW-1:0]          pos_mem  [MAX_TAPS];
   logic [SAMPLE_BITS-1:0] hist_rd_ff;
   logic [AW-1:0]          pos_rd_ff;
   logic                   hist_we;
   logic [AW-1:0]          hist_waddr;
   logic [SAMPLE_BITS-1:0] hist_wdata;
   logic                   pos_we;
   logic [TIW-1:0]         pos_waddr;
   logic [AW-1:0]          pos_wdata;

   // Registers
   mted_pkg::state_type    state_ff, state_in;
   logic [CW-1:0]          clr_ff, clr_in;
   logic [AW-1:0]          wp_ff, wp_in;
   logic [SAMPLE_BITS-1:0] dry_ff, dry_in;
   logic [TW-1:0]          tap_ff, tap_in;
   logic [TGW-1:0]         target_ff, target_in;
   logic [GB-1:0]          gain_ff, gain_in;
   logic [ACCB-1:0]        acc_ff, acc_in;
   logic [XB-1:0]          x_ff, x_in;
   logic [QW-1:0]          q_ff, q_in;
   logic [MAGB-1:0]        mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;

   // Shared multiplier
   logic signed [A_BITS-1:0] op_a;
   logic signed [B_BITS-1:0] op_b;
   logic signed [PB-1:0]     prod;

   // Derived values
   logic [LCW-1:0]         dl_ext;
   logic [LW-1:0]          len;
   logic [TCW-1:0]         tc_ext;
   logic [TW-1:0]          taps;
   logic [LW-1:0]          wp_inc;
   logic [AW-1:0]          wp_next;
   logic [LGW-1:0]         lag;
   logic                   match;
   logic [LW-1:0]          rd_inc;
   logic [AW-1:0]          rd_new;
   logic [GB-1:0]          q1;
   logic [XB-1:0]          gain_rem;
   logic [GB-1:0]          gain_next;
   logic [ACCB-1:0]        clip;
   logic [ACCB-1:0]        clip_abs;
   logic [SAMPLE_BITS-1:0] q2;
   logic [MAGB-1:0]        fin_rem;
   logic [SAMPLE_BITS-1:0] q_fin;
   logic [SAMPLE_BITS-1:0] result;
   logic                   last_tap;
   logic                   clr_hist;
   logic                   clr_pos;

   mted_mul #(
      .A_BITS (A_BITS),
      .B_BITS (B_BITS)
   ) u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign req_ready         = (state_ff == mted_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_echoed_sample = $signed(rsp_data_ff);

   // Effective length and tap count
   always_comb begin
      dl_ext = LCW'(regs.delay_length);
      if (dl_ext == '0) begin
         len = LW'(1);
      end else if (dl_ext > LCW'(HISTORY_DEPTH)) begin
         len = LW'(HISTORY_DEPTH);
      end else begin
         len = LW'(dl_ext);
      end
      tc_ext = TCW'(regs.tap_count);
      if (tc_ext > TCW'(MAX_TAPS)) begin
         taps = TW'(MAX_TAPS);
      end else begin
         taps = TW'(tc_ext);
      end
   end

   // Write pointer advance
   assign wp_inc  = LW'(wp_ff) + LW'(1);
   assign wp_next = (wp_inc >= len) ? '0 : wp_inc[AW-1:0];

   // Tap lag behind the new write pointer and read pointer advance
   assign lag = (wp_ff >= pos_rd_ff) ? (LGW'(wp_ff) - LGW'(pos_rd_ff))
                                     : (LGW'(len) + LGW'(wp_ff) - LGW'(pos_rd_ff));
   assign match  = !lag[LGW-1] && (MW'(lag[LGW-2:0]) == MW'(target_ff));
   assign rd_inc = LW'(pos_rd_ff) + LW'(match);
   assign rd_new = (rd_inc >= len) ? '0 : rd_inc[AW-1:0];

   // Gain update: reciprocal quotient plus one correction step
   assign q1        = prod[K1+GB-1:K1];
   assign gain_rem  = x_ff - prod[XB-1:0];
   assign gain_next = q_ff[GB-1:0]
                      + GB'(gain_rem >= XB'(mted_pkg::GAIN_SCALE));

   // Final scaling: clip, magnitude, quotient, sign
   always_comb begin
      if ($signed(acc_ff) > $signed(ACCB'(ACC_HI))) begin
         clip = ACCB'(ACC_HI);
      end else if ($signed(acc_ff) < $signed(ACCB'(ACC_LO))) begin
         clip = ACCB'(ACC_LO);
      end else begin
         clip = acc_ff;
      end
      clip_abs = clip[ACCB-1] ? (~clip + ACCB'(1)) : clip;
   end

   assign q2      = prod[K2+SAMPLE_BITS-1:K2];
   assign fin_rem = mag_ff - prod[MAGB-1:0];
   assign q_fin   = q_ff[SAMPLE_BITS-1:0]
                    + SAMPLE_BITS'(fin_rem >= MAGB'(mted_pkg::GAIN_SCALE));
   assign result  = neg_ff ? (~q_fin + SAMPLE_BITS'(1)) : q_fin;

   assign last_tap = ((TW + 1)'(tap_ff) + (TW + 1)'(1)) == (TW + 1)'(taps);
   assign clr_hist = CCW'(clr_ff) < CCW'(HISTORY_DEPTH);
   assign clr_pos  = CCW'(clr_ff) < CCW'(MAX_TAPS);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      wp_in        = wp_ff;
      dry_in       = dry_ff;
      tap_in       = tap_ff;
      target_in    = target_ff;
      gain_in      = gain_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      q_in         = q_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      hist_we      = 1'b0;
      hist_waddr   = wp_ff;
      hist_wdata   = dry_ff;
      pos_we       = 1'b0;
      pos_waddr    = tap_ff[TIW-1:0];
      pos_wdata    = rd_new;
      op_a         = '0;
      op_b         = '0;

      // Result taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         mted_pkg::ST_CLEAR: begin
            hist_we    = clr_hist;
            hist_waddr = clr_ff[AW-1:0];
            hist_wdata = '0;
            pos_we     = clr_pos;
            pos_waddr  = clr_ff[TIW-1:0];
            pos_wdata  = '0;
            if (clr_ff == CW'(CLR_DEPTH - 1)) begin
               state_in = mted_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + CW'(1);
            end
         end
         mted_pkg::ST_IDLE: begin
            if (req_valid) begin
               dry_in   = req_sample;
               state_in = mted_pkg::ST_DRY;
            end
         end
         mted_pkg::ST_DRY: begin
            hist_we   = 1'b1;
            wp_in     = wp_next;
            tap_in    = '0;
            target_in = TGW'(regs.first_tap_distance);
            gain_in   = GB'(regs.decay_permille);
            op_a      = A_BITS'($signed(dry_ff));
            op_b      = B_BITS'(mted_pkg::GAIN_SCALE);
            state_in  = mted_pkg::ST_LOAD;
         end
         mted_pkg::ST_LOAD: begin
            acc_in = prod[ACCB-1:0];
            if (taps == '0) begin
               state_in = mted_pkg::ST_FIN;
            end else begin
               state_in = mted_pkg::ST_LAG;
            end
         end
         mted_pkg::ST_POS: begin
            state_in = mted_pkg::ST_LAG;
         end
         mted_pkg::ST_LAG: begin
            pos_we   = 1'b1;
            state_in = mted_pkg::ST_MAC;
         end
         mted_pkg::ST_MAC: begin
            op_a     = A_BITS'($signed(hist_rd_ff));
            op_b     = B_BITS'(gain_ff);
            state_in = mted_pkg::ST_GAIN;
         end
         mted_pkg::ST_GAIN: begin
            acc_in   = acc_ff + prod[ACCB-1:0];
            op_a     = A_BITS'(gain_ff);
            op_b     = B_BITS'(regs.decay_permille);
            state_in = mted_pkg::ST_GQ;
         end
         mted_pkg::ST_GQ: begin
            x_in     = prod[XB-1:0];
            op_a     = A_BITS'(prod[XB-1:0]);
            op_b     = B_BITS'(M1);
            state_in = mted_pkg::ST_GC;
         end
         mted_pkg::ST_GC: begin
            q_in     = QW'(q1);
            op_a     = A_BITS'(q1);
            op_b     = B_BITS'(mted_pkg::GAIN_SCALE);
            state_in = mted_pkg::ST_GF;
         end
         mted_pkg::ST_GF: begin
            gain_in = gain_next;
            if (last_tap) begin
               state_in = mted_pkg::ST_FIN;
            end else begin
               tap_in    = tap_ff + TW'(1);
               target_in = target_ff + TGW'(regs.tap_spacing);
               state_in  = mted_pkg::ST_POS;
            end
         end
         mted_pkg::ST_FIN: begin
            mag_in   = clip_abs[MAGB-1:0];
            neg_in   = clip[ACCB-1];
            op_a     = A_BITS'(clip_abs[MAGB-1:0]);
            op_b     = B_BITS'(M2);
            state_in = mted_pkg::ST_FQ;
         end
         mted_pkg::ST_FQ: begin
            q_in     = QW'(q2);
            op_a     = A_BITS'(q2);
            op_b     = B_BITS'(mted_pkg::GAIN_SCALE);
            state_in = mted_pkg::ST_FC;
         end
         mted_pkg::ST_FC: begin
            // Keep the correction product steady while the result waits
            op_a = A_BITS'(q_ff[SAMPLE_BITS-1:0]);
            op_b = B_BITS'(mted_pkg::GAIN_SCALE);
            // Wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               state_in     = mted_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mted_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mted_pkg::ST_CLEAR;
         clr_ff       <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      dry_ff      <= dry_in;
      tap_ff      <= tap_in;
      target_ff   <= target_in;
      gain_ff     <= gain_in;
      acc_ff      <= acc_in;
      x_ff        <= x_in;
      q_ff        <= q_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Sample history
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      hist_rd_ff <= hist_mem[rd_new];
   end

   // Tap read positions
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_waddr] <= pos_wdata;
      end
      pos_rd_ff <= pos_mem[tap_ff[TIW-1:0]];
   end

   // Checks
   assert property (@(posedge clock) reset |=> (state_ff == mted_pkg::ST_CLEAR)
                    && (clr_ff == '0))
      else $error("clearing sweep does not restart after reset");

   assert property (@(posedge clock) disable iff (reset)
                    req_valid && req_ready |=> state_ff == mted_pkg::ST_DRY)
      else $error("accepted transaction did not start processing");

   assert property (@(posedge clock) disable iff (reset)
                    state_ff == mted_pkg::ST_LAG |-> tap_ff < taps)
      else $error("tap index beyond tap count");

   assert property (@(posedge clock) disable iff (reset)
                    state_ff == mted_pkg::ST_GF |-> gain_rem < XB'(2 * mted_pkg::GAIN_SCALE))
      else $error("gain quotient needs more than one correction");

   assert property (@(posedge clock) disable iff (reset)
                    state_ff == mted_pkg::ST_FC |-> fin_rem < MAGB'(2 * mted_pkg::GAIN_SCALE))
      else $error("output quotient needs more than one correction");

endmodule
